### rtl/rae_pkg.sv
// Shared widths, energy bounds and the control type for the rolling average tracker.
// No dependencies.
`default_nettype none

package rae_pkg;

    localparam int SAMPLE_W = 24;
    localparam int ENERGY_W = 48;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    // command to the serial accumulator
    typedef struct packed {
        logic start;  // begin one update pass
        logic drop;   // window is full: take the oldest sample out of the sum
    } t_acc_cmd;

endpackage

`default_nettype wire

### rtl/rolling_average_energy_tracker_top.sv
// Top level: sample ring, sequencing, serial accumulator, divider and output register.
// Depends on rae_pkg, rae_serial_acc and rae_divider.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_power_sample
//  output  | o_out_valid | i_out_ready | o_average_power, o_energy_total, o_samples_held
//
// Only one word is in flight: it passes the ring read, the launch, the bit-serial adder, the
// divider with its sign fix and the output load. A new word is taken only in the idle state
// after that load, so the next word waits until the previous result is in the output register.
// Reset is synchronous, active low, and clears sum, energy, fill count and position.
// A finished result waits in the output register; the next word is taken meanwhile
// and holds before its own load until the output register is free.
`default_nettype none

module rolling_average_energy_tracker_top
    import rae_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0]          i_power_sample,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed      [SAMPLE_W-1:0]          o_average_power,
    output logic signed      [ENERGY_W-1:0]          o_energy_total,
    output logic             [$clog2(WINDOW+1)-1:0]  o_samples_held
);

    localparam int HELD_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + HELD_W;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
    localparam logic [HELD_W-1:0] FILL_FULL = HELD_W'(WINDOW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAUNCH,
        S_ACC,
        S_DIV,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_old;
    logic [PTR_W-1:0]    r_pos;
    logic [HELD_W-1:0]   r_fill;
    logic                r_drop;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_avg;
    logic [ENERGY_W-1:0] r_energy;
    logic [HELD_W-1:0]   r_held;

    t_acc_cmd            w_acc_cmd;
    logic [SUM_W-1:0]    w_sum;
    logic [ENERGY_W-1:0] w_energy;
    logic                w_acc_done;
    logic [SAMPLE_W-1:0] w_quot;
    logic                w_div_done;
    logic                w_out_free;

    assign w_out_free      = !r_out_valid || i_out_ready;
    assign w_acc_cmd.start = (r_state == S_LAUNCH);
    assign w_acc_cmd.drop  = r_drop;

    // read before write: r_old gets the word being replaced
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_ring[r_pos] <= r_sample;
            r_old         <= r_ring[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sample <= i_power_sample;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_drop <= (r_fill == FILL_FULL);
                    if (r_fill != FILL_FULL) begin
                        r_fill <= r_fill + HELD_W'(1);
                    end
                    r_pos   <= (r_pos == PTR_LAST) ? '0 : r_pos + PTR_W'(1);
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_acc_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_avg       <= w_quot;
                        r_energy    <= w_energy;
                        r_held      <= r_fill;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rae_serial_acc #(
        .SUM_W (SUM_W)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_acc_cmd),
        .i_sample (r_sample),
        .i_old    (r_old),
        .o_sum    (w_sum),
        .o_energy (w_energy),
        .o_done   (w_acc_done)
    );

    rae_divider #(
        .SUM_W  (SUM_W),
        .HELD_W (HELD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc_done),
        .i_dividend (w_sum),
        .i_divisor  (r_fill),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_average_power = r_avg;
    assign o_energy_total  = r_energy;
    assign o_samples_held  = r_held;

endmodule

`default_nettype wire

### rtl/rae_serial_acc.sv
// Bit-serial update of the window sum and the saturating energy accumulator.
// Depends on rae_pkg.
`default_nettype none

module rae_serial_acc
    import rae_pkg::*;
#(
    parameter int SUM_W = 27
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_acc_cmd            i_cmd,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [SAMPLE_W-1:0] i_old,
    output logic      [SUM_W-1:0]    o_sum,
    output logic      [ENERGY_W-1:0] o_energy,
    output logic                     o_done
);

    localparam int CNT_W = $clog2(ENERGY_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENERGY_W - 1);
    localparam logic [CNT_W-1:0] CNT_SUM  = CNT_W'(SUM_W);

    logic [SUM_W-1:0]    r_sum;
    logic [ENERGY_W-1:0] r_energy;
    logic [SAMPLE_W-1:0] r_new;
    logic [SAMPLE_W-1:0] r_old;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic                r_c_add;
    logic                r_c_sub;
    logic                r_c_en;
    logic                r_acc_sign;
    logic                r_smp_sign;

    logic w_t;
    logic w_s;
    logic w_e;
    logic w_ovf;
    logic n_c_add;
    logic n_c_sub;
    logic n_c_en;

    // sum + new, then + ~old with carry-in one: sum + new - old
    always_comb begin
        w_t     = r_sum[0] ^ r_new[0] ^ r_c_add;
        n_c_add = (r_sum[0] & r_new[0]) | (r_c_add & (r_sum[0] ^ r_new[0]));
        w_s     = w_t ^ ~r_old[0] ^ r_c_sub;
        n_c_sub = (w_t & ~r_old[0]) | (r_c_sub & (w_t ^ ~r_old[0]));
        w_e     = r_energy[0] ^ r_new[0] ^ r_c_en;
        n_c_en  = (r_energy[0] & r_new[0]) | (r_c_en & (r_energy[0] ^ r_new[0]));
        w_ovf   = (r_acc_sign == r_smp_sign) && (w_e != r_acc_sign);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_energy <= '0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_new      <= i_sample;
                // a zero old word makes the subtraction a no-op
                r_old      <= i_cmd.drop ? i_old : '0;
                r_cnt      <= '0;
                r_busy     <= 1'b1;
                r_c_add    <= 1'b0;
                r_c_sub    <= 1'b1;
                r_c_en     <= 1'b0;
                r_acc_sign <= r_energy[ENERGY_W-1];
                r_smp_sign <= i_sample[SAMPLE_W-1];
            end else if (r_busy) begin
                // arithmetic shift keeps sign extension going past bit 23
                r_new   <= {r_new[SAMPLE_W-1], r_new[SAMPLE_W-1:1]};
                r_old   <= {r_old[SAMPLE_W-1], r_old[SAMPLE_W-1:1]};
                r_c_add <= n_c_add;
                r_c_sub <= n_c_sub;
                r_c_en  <= n_c_en;
                r_cnt   <= r_cnt + CNT_W'(1);
                if (r_cnt < CNT_SUM) begin
                    r_sum <= {w_s, r_sum[SUM_W-1:1]};
                end
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (w_ovf) begin
                        r_energy <= r_acc_sign ? ENERGY_MIN : ENERGY_MAX;
                    end else begin
                        r_energy <= {w_e, r_energy[ENERGY_W-1:1]};
                    end
                end else begin
                    r_energy <= {w_e, r_energy[ENERGY_W-1:1]};
                end
            end
        end
    end

    assign o_sum    = r_sum;
    assign o_energy = r_energy;
    assign o_done   = r_done;

endmodule

`default_nettype wire

### rtl/rae_divider.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on rae_pkg.
`default_nettype none

module rae_divider
    import rae_pkg::*;
#(
    parameter int SUM_W  = 27,
    parameter int HELD_W = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SUM_W-1:0]    i_dividend,
    input  wire logic [HELD_W-1:0]   i_divisor,
    output logic      [SAMPLE_W-1:0] o_quot,
    output logic                     o_done
);

    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

    logic [SUM_W-1:0]    r_q;
    logic [HELD_W-1:0]   r_rem;
    logic [HELD_W-1:0]   r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;
    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    logic [SAMPLE_W-1:0] r_quot;

    logic [HELD_W:0]     w_rem_sh;
    logic [HELD_W:0]     w_diff;
    logic                w_qbit;
    logic [SUM_W-1:0]    w_abs;
    logic [SAMPLE_W-1:0] w_mag;

    always_comb begin
        w_rem_sh = {r_rem, r_q[SUM_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_div};
        w_qbit   = (w_rem_sh >= {1'b0, r_div});
        w_abs    = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
        w_mag    = r_q[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= w_abs;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[SUM_W-2:0], w_qbit};
                r_rem <= w_qbit ? w_diff[HELD_W-1:0] : w_rem_sh[HELD_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                // restore the sign of the dividend
                r_quot <= r_neg ? (~w_mag + SAMPLE_W'(1)) : w_mag;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

`default_nettype wire
